// ===== rtl/tkz_pkg.sv =====
// Shared constants, types and the command/status bundles of the document tokenizer.
// Used by tkz_ctrl, tkz_dp and document_tokenizer; depends on nothing.

package tkz_pkg;

	localparam int MAX_TOKEN       = 25;
	localparam int DOC_COUNT_BITS  = 16;
	localparam int DOC_LENGTH_BITS = 24;

	// Word letters kept in the buffer, and the widths that follow from it.
	localparam int BUF_DEPTH = MAX_TOKEN - 1;
	localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int RAW_W     = $clog2(MAX_TOKEN + 1);

	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_TAG  = 2'd1,
		KIND_ID   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_WORD = 2'd1,
		CLS_TAG  = 2'd2,
		CLS_ID   = 2'd3
	} cls_t;

	typedef enum logic {
		ST_RUN   = 1'b0,
		ST_FLUSH = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic step;   // process the word accepted this cycle
		logic emit;   // load the next buffered letter into the output register
	} tkz_cmd_t;

	typedef struct packed {
		logic emit_now;     // the input word gives one result at once
		logic flush_start;  // the input word closes a word that is kept
		logic flush_done;   // the letter being flushed is the last one
	} tkz_sts_t;

endpackage

// ===== rtl/tkz_ctrl.sv =====
// Controller of the document tokenizer: run/flush state machine and both handshakes.
// Depends on tkz_pkg; drives tkz_dp through tkz_cmd_t and reads tkz_sts_t.

module tkz_ctrl
	import tkz_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  tkz_sts_t sts,
	output tkz_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;
	logic        out_free;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_RUN: begin
				in_stall = !out_free;
				accept   = in_valid && out_free;
				cmd.step = accept;
				if (accept && sts.flush_start) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.emit = out_free;
				if (out_free && sts.flush_done) begin
					state_d = ST_RUN;
				end
			end
		endcase
		if ((cmd.step && sts.emit_now) || cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_step_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.emit))
		else $error("step and flush emit in the same cycle");

	a_flush_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.flush_start) |=> (state_q == ST_FLUSH))
		else $error("kept word did not start a flush");

	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !(cmd.emit && sts.flush_done)) |=> (state_q == ST_FLUSH))
		else $error("flush left before its last letter");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> (!cmd.step && !cmd.emit))
		else $error("output register loaded while its word is stalled");
`endif

endmodule

// ===== rtl/tkz_dp.sv =====
// Datapath of the document tokenizer: token state, tag matcher, word buffer,
// counters and the output register. Depends on tkz_pkg; commanded by tkz_ctrl.

module tkz_dp
	import tkz_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 ch,
	input  logic                       line_end,
	input  tkz_cmd_t                   cmd,
	output tkz_sts_t                   sts,
	output logic [7:0]                 out_char,
	output logic [1:0]                 kind,
	output logic                       token_last,
	output logic [DOC_COUNT_BITS-1:0]  doc_count,
	output logic                       doc_closed,
	output logic [DOC_LENGTH_BITS-1:0] doc_length
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UC_C  = 8'h43;
	localparam logic [7:0] CH_UC_D  = 8'h44;
	localparam logic [7:0] CH_UC_N  = 8'h4E;
	localparam logic [7:0] CH_UC_O  = 8'h4F;

	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_OPEN  = 4'd1;
	localparam logic [3:0] M_DOCNO = 4'd7;
	localparam logic [3:0] M_SLASH = 4'd8;
	localparam logic [3:0] M_CLOSE = 4'd12;

	localparam logic [RAW_W-1:0]           RAW_MAX   = RAW_W'(MAX_TOKEN);
	localparam logic [CNT_W-1:0]           CNT_MAX   = CNT_W'(BUF_DEPTH);
	localparam logic [DOC_COUNT_BITS-1:0]  DOCS_MAX  = '1;
	localparam logic [DOC_LENGTH_BITS-1:0] WORDS_MAX = '1;

	// Advances the recogniser for "<DOCNO>" (states 1 to 7) and "</DOC>" (8 to 12).
	function automatic logic [3:0] match_next(input logic [3:0] s, input logic [7:0] c);
		logic [3:0] r;
		r = M_IDLE;
		unique case (s)
			4'd1:    r = (c == CH_UC_D) ? 4'd2 : ((c == CH_SLASH) ? M_SLASH : M_IDLE);
			4'd2:    r = (c == CH_UC_O) ? 4'd3 : M_IDLE;
			4'd3:    r = (c == CH_UC_C) ? 4'd4 : M_IDLE;
			4'd4:    r = (c == CH_UC_N) ? 4'd5 : M_IDLE;
			4'd5:    r = (c == CH_UC_O) ? 4'd6 : M_IDLE;
			4'd6:    r = (c == CH_GT)   ? M_DOCNO : M_IDLE;
			4'd8:    r = (c == CH_UC_D) ? 4'd9 : M_IDLE;
			4'd9:    r = (c == CH_UC_O) ? 4'd10 : M_IDLE;
			4'd10:   r = (c == CH_UC_C) ? 4'd11 : M_IDLE;
			4'd11:   r = (c == CH_GT)   ? M_CLOSE : M_IDLE;
			default: r = M_IDLE;
		endcase
		return r;
	endfunction

	// Token state
	cls_t                       cls_q, cls_d;
	logic [CNT_W-1:0]           lc_q, lc_d;
	logic [RAW_W-1:0]           raw_q, raw_d;
	logic [7:0]                 held_q, held_d;
	logic                       held_valid_q, held_valid_d;
	logic [3:0]                 match_q, match_d;
	logic                       pending_q, pending_d;
	logic [DOC_COUNT_BITS-1:0]  docs_q, docs_d;
	logic [DOC_LENGTH_BITS-1:0] words_q, words_d;
	logic [IDX_W-1:0]           flush_idx_q;
	logic [IDX_W-1:0]           flush_last_q;

	logic [7:0] word_buf [BUF_DEPTH];

	// Result of the current input word
	logic                       delim;
	logic                       is_letter;
	logic [7:0]                 lower_ch;
	logic                       buf_we;
	cls_t                       eff_cls;
	logic                       emit_now;
	logic                       flush_start;
	logic [7:0]                 e_char;
	kind_t                      e_kind;
	logic                       e_last;
	logic                       e_closed;
	logic [DOC_LENGTH_BITS-1:0] e_len;

	// Output register
	logic [7:0]                 out_char_q;
	kind_t                      kind_q;
	logic                       last_q;
	logic [DOC_COUNT_BITS-1:0]  count_q;
	logic                       closed_q;
	logic [DOC_LENGTH_BITS-1:0] len_q;

	always_comb begin
		delim     = line_end || (ch == CH_SPACE);
		is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
		lower_ch  = ch | 8'h20;

		cls_d        = cls_q;
		lc_d         = lc_q;
		raw_d        = raw_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		match_d      = match_q;
		pending_d    = pending_q;
		docs_d       = docs_q;
		words_d      = words_q;
		eff_cls      = cls_q;
		buf_we       = 1'b0;
		emit_now     = 1'b0;
		flush_start  = 1'b0;
		e_char       = held_q;
		e_kind       = KIND_TAG;
		e_last       = 1'b0;
		e_closed     = 1'b0;
		e_len        = '0;

		if (delim) begin
			unique case (cls_q)
				CLS_WORD: begin
					if ((raw_q < RAW_MAX) && (lc_q != '0)) begin
						flush_start = 1'b1;
						if (words_q != WORDS_MAX) begin
							words_d = words_q + 1'b1;
						end
					end
				end
				CLS_TAG: begin
					emit_now = 1'b1;
					e_last   = 1'b1;
					if (match_q == M_CLOSE) begin
						e_closed = 1'b1;
						e_len    = words_q;
						words_d  = '0;
					end else if (match_q == M_DOCNO) begin
						pending_d = 1'b1;
					end
				end
				CLS_ID: begin
					emit_now = 1'b1;
					e_kind   = KIND_ID;
					e_last   = 1'b1;
				end
				CLS_NONE: begin
				end
			endcase
			cls_d        = CLS_NONE;
			lc_d         = '0;
			raw_d        = '0;
			held_d       = '0;
			held_valid_d = 1'b0;
			match_d      = M_IDLE;
		end else begin
			priority if (cls_q == CLS_NONE && pending_q) begin
				eff_cls   = CLS_ID;
				pending_d = 1'b0;
				if (docs_q != DOCS_MAX) begin
					docs_d = docs_q + 1'b1;
				end
			end else if (cls_q == CLS_NONE && ch == CH_LT) begin
				// Opening '<' of a tag is only held; nothing goes out yet.
				eff_cls = CLS_NONE;
				cls_d   = CLS_TAG;
				match_d = M_OPEN;
			end else if (cls_q == CLS_NONE) begin
				eff_cls = CLS_WORD;
			end else if (cls_q == CLS_TAG) begin
				match_d = match_next(match_q, ch);
			end else begin
			end

			unique case (eff_cls)
				CLS_WORD: begin
					cls_d = CLS_WORD;
					if (raw_q < RAW_MAX) begin
						raw_d = raw_q + 1'b1;
					end
					if (is_letter && (lc_q < CNT_MAX)) begin
						buf_we = 1'b1;
						lc_d   = lc_q + 1'b1;
					end
				end
				CLS_TAG, CLS_ID: begin
					cls_d        = eff_cls;
					emit_now     = held_valid_q;
					e_kind       = (eff_cls == CLS_ID) ? KIND_ID : KIND_TAG;
					held_d       = ch;
					held_valid_d = 1'b1;
				end
				CLS_NONE: begin
					held_d       = ch;
					held_valid_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q        <= CLS_NONE;
			lc_q         <= '0;
			raw_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			match_q      <= M_IDLE;
			pending_q    <= 1'b0;
			docs_q       <= '0;
			words_q      <= '0;
			flush_idx_q  <= '0;
			flush_last_q <= '0;
		end else begin
			if (cmd.step) begin
				cls_q        <= cls_d;
				lc_q         <= lc_d;
				raw_q        <= raw_d;
				held_q       <= held_d;
				held_valid_q <= held_valid_d;
				match_q      <= match_d;
				pending_q    <= pending_d;
				docs_q       <= docs_d;
				words_q      <= words_d;
			end
			if (cmd.step && flush_start) begin
				flush_idx_q  <= '0;
				flush_last_q <= IDX_W'(lc_q - CNT_W'(1));
			end else if (cmd.emit) begin
				flush_idx_q <= flush_idx_q + 1'b1;
			end
		end
	end

	// Letters of the open word; entries above the fill count are never read.
	always_ff @(posedge clk) begin
		if (cmd.step && buf_we) begin
			word_buf[lc_q[IDX_W-1:0]] <= lower_ch;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit_now) begin
			out_char_q <= e_char;
			kind_q     <= e_kind;
			last_q     <= e_last;
			count_q    <= docs_q;
			closed_q   <= e_closed;
			len_q      <= e_len;
		end else if (cmd.emit) begin
			out_char_q <= word_buf[flush_idx_q];
			kind_q     <= KIND_WORD;
			last_q     <= (flush_idx_q == flush_last_q);
			count_q    <= docs_q;
			closed_q   <= 1'b0;
			len_q      <= '0;
		end
	end

	assign sts.emit_now    = emit_now;
	assign sts.flush_start = flush_start;
	assign sts.flush_done  = (flush_idx_q == flush_last_q);

	assign out_char   = out_char_q;
	assign kind       = kind_q;
	assign token_last = last_q;
	assign doc_count  = count_q;
	assign doc_closed = closed_q;
	assign doc_length = len_q;

endmodule

// ===== rtl/document_tokenizer.sv =====
// Top level of the document tokenizer: joins the controller and the datapath.
// Depends on tkz_pkg, tkz_ctrl and tkz_dp.

// Splits a character stream into tokens on spaces and line ends. Tags (tokens that
// start with '<') and the document id after a <DOCNO> tag come out raw, one
// character a word, held back by one character so that the last one carries
// token_last; the </DOC> tag's last word carries doc_closed and doc_length. Other
// tokens are words: letters only, lower case, dropped when too long or empty, and
// sent out when their delimiter arrives. Intake runs at one character a clock except
// when stalled. A kept word's delimiter stalls intake while its letters leave the
// buffer through a single read port, one each cycle that the output register is free.
// Each result sits in an output register, and intake pauses while it waits to be taken.

module document_tokenizer
	import tkz_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 ch,
	input  logic                       line_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_char,
	output logic [1:0]                 kind,
	output logic                       token_last,
	output logic [DOC_COUNT_BITS-1:0]  doc_count,
	output logic                       doc_closed,
	output logic [DOC_LENGTH_BITS-1:0] doc_length
);

	tkz_cmd_t cmd;
	tkz_sts_t sts;

	tkz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tkz_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.line_end   (line_end),
		.cmd        (cmd),
		.sts        (sts),
		.out_char   (out_char),
		.kind       (kind),
		.token_last (token_last),
		.doc_count  (doc_count),
		.doc_closed (doc_closed),
		.doc_length (doc_length)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for document_tokenizer: feeds character streams of documents,
// tags, words and noise, predicts every emitted token character and compares them.
// Depends on tkz_pkg and the document_tokenizer RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tkz_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 2 * MAX_TOKEN + 16;
	localparam logic [7:0] SPACE = 8'd32;
	localparam logic [7:0] LT = "<";
	localparam logic [8*7-1:0] OPEN_TAG = "<DOCNO>";
	localparam logic [8*6-1:0] CLOSE_TAG = "</DOC>";

	// Progress of the tag matcher: after '<', after the whole <DOCNO>, after '</',
	// and after the whole </DOC>.
	localparam int M_NONE = 0;
	localparam int M_LT = 1;
	localparam int M_DOCNO = 7;
	localparam int M_SLASH = 8;
	localparam int M_CLOSE = 12;

	typedef struct {
		logic [7:0] c;
		logic eol;
		bit wait_drain;
	} char_item_t;

	typedef struct {
		logic [7:0] c;
		kind_t k;
		logic last;
		logic [DOC_COUNT_BITS-1:0] docs;
		logic closed;
		logic [DOC_LENGTH_BITS-1:0] len;
	} token_out_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] ch;
	logic line_end;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_char;
	logic [1:0] kind;
	logic token_last;
	logic [DOC_COUNT_BITS-1:0] doc_count;
	logic doc_closed;
	logic [DOC_LENGTH_BITS-1:0] doc_length;

	char_item_t pending_chars[$];
	token_out_t expected_tokens[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycle_count = 0;

	// Tokenizer state as the predictor sees it.
	logic [7:0] word_letters [BUF_DEPTH];
	int letter_total = 0;
	int raw_total = 0;
	cls_t open_cls = CLS_NONE;
	logic [7:0] held = '0;
	bit held_ok = 0;
	int match_st = M_NONE;
	bit docno_wait = 0;
	logic [DOC_COUNT_BITS-1:0] docs_seen = '0;
	logic [DOC_LENGTH_BITS-1:0] words_seen = '0;

	document_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.kind(kind),
		.token_last(token_last),
		.doc_count(doc_count),
		.doc_closed(doc_closed),
		.doc_length(doc_length)
	);

	function automatic int next_match(int s, logic [7:0] c);
		if (s >= M_LT && s < M_DOCNO) begin
			if (c == OPEN_TAG[8*(6-s) +: 8])
				return s + 1;
			if (s == M_LT && c == "/")
				return M_SLASH;
			return M_NONE;
		end
		if (s >= M_SLASH && s < M_CLOSE) begin
			if (c == CLOSE_TAG[8*(11-s) +: 8])
				return s + 1;
			return M_NONE;
		end
		return M_NONE;
	endfunction

	function automatic void emit_token(logic [7:0] c, kind_t k, logic last, logic closed,
			logic [DOC_LENGTH_BITS-1:0] len);
		token_out_t t;
		t.c = c;
		t.k = k;
		t.last = last;
		t.docs = docs_seen;
		t.closed = closed;
		t.len = len;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	function automatic void close_open_token();
		if (open_cls == CLS_WORD) begin
			if (raw_total < MAX_TOKEN && letter_total > 0) begin
				for (int i = 0; i < letter_total; i++)
					emit_token(word_letters[i], KIND_WORD, i + 1 == letter_total, 1'b0, '0);
				if (words_seen != '1)
					words_seen++;
			end
		end else if (open_cls == CLS_TAG) begin
			if (match_st == M_CLOSE) begin
				emit_token(held, KIND_TAG, 1'b1, 1'b1, words_seen);
				words_seen = '0;
			end else begin
				emit_token(held, KIND_TAG, 1'b1, 1'b0, '0);
				if (match_st == M_DOCNO)
					docno_wait = 1;
			end
		end else if (open_cls == CLS_ID) begin
			emit_token(held, KIND_ID, 1'b1, 1'b0, '0);
		end
		open_cls = CLS_NONE;
		letter_total = 0;
		raw_total = 0;
		held_ok = 0;
		held = '0;
		match_st = M_NONE;
	endfunction

	function automatic void tokenize_char(logic [7:0] c, logic eol);
		if (eol || c == SPACE) begin
			close_open_token();
			return;
		end
		if (open_cls == CLS_NONE) begin
			// A token after <DOCNO> is the id even when it starts with '<'.
			if (docno_wait) begin
				open_cls = CLS_ID;
				docno_wait = 0;
				if (docs_seen != '1)
					docs_seen++;
			end else if (c == LT) begin
				open_cls = CLS_TAG;
				match_st = M_LT;
				held = c;
				held_ok = 1;
				return;
			end else begin
				open_cls = CLS_WORD;
			end
		end else if (open_cls == CLS_TAG) begin
			match_st = next_match(match_st, c);
		end
		if (open_cls == CLS_WORD) begin
			if (raw_total < MAX_TOKEN)
				raw_total++;
			if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && letter_total < BUF_DEPTH) begin
				word_letters[letter_total] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
				letter_total++;
			end
			return;
		end
		if (held_ok)
			emit_token(held, (open_cls == CLS_TAG) ? KIND_TAG : KIND_ID, 1'b0, 1'b0, '0);
		held = c;
		held_ok = 1;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	function automatic void push_char(logic [7:0] c, logic eol = 1'b0, bit drain = 0);
		char_item_t it;
		it.c = c;
		it.eol = eol;
		it.wait_drain = drain;
		pending_chars.insert(pending_chars.size(), it);
	endfunction

	// The character that goes with a line end is ignored, so it is left random.
	function automatic void push_eol();
		push_char(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == 8'h0A)
				push_eol();
			else
				push_char(s[i]);
		end
	endfunction

	function automatic void push_gap();
		int r;
		r = $urandom_range(0, 5);
		if (r < 3) begin
			push_char(SPACE);
		end else if (r < 5) begin
			push_eol();
		end else begin
			push_char(SPACE);
			push_eol();
		end
	endfunction

	function automatic logic [7:0] random_word_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'($urandom_range("A", "Z"));
			1, 2: c = 8'($urandom_range("a", "z"));
			default: begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == SPACE);
			end
		endcase
		return c;
	endfunction

	function automatic void push_word(int n);
		repeat (n)
			push_char(random_word_char());
	endfunction

	function automatic void push_document();
		push_text("<DOC>");
		push_gap();
		push_text("<DOCNO>");
		push_gap();
		if ($urandom_range(0, 4) == 0)
			push_char(LT);
		push_word($urandom_range(1, 4));
		push_gap();
		repeat ($urandom_range(0, 3)) begin
			push_word($urandom_range(1, 7));
			push_gap();
		end
		push_text("</DOC>");
		push_gap();
	endfunction

	function automatic void push_broken_tag();
		case ($urandom_range(0, 6))
			0: push_text("<DOCN");
			1: push_text("</DO");
			2: push_text("<DOCNOX>");
			3: push_text("</DOCX");
			4: push_text("<");
			5: push_text("<DOCNO>x");
			default: push_text("</DOC>>");
		endcase
		push_gap();
	endfunction

	function automatic void push_random_phase(int min_chars);
		int start;
		int r;
		start = pending_chars.size();
		while (pending_chars.size() - start < min_chars) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				push_document();
			end else if (r < 62) begin
				push_word($urandom_range(1, 7));
				push_gap();
			end else if (r < 72) begin
				// Around the length limit: some kept, some dropped.
				repeat ($urandom_range(MAX_TOKEN - 3, MAX_TOKEN + 2))
					push_char(($urandom_range(0, 7) == 0) ? "7" : 8'($urandom_range("a", "z")));
				push_gap();
			end else if (r < 82) begin
				push_broken_tag();
			end else begin
				repeat ($urandom_range(1, 3))
					push_char(8'($urandom_range(0, 255)));
				push_gap();
			end
		end
	endfunction

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Driver: a word is held until taken; a new one follows at random unless a drain
	// is requested and results are still due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			line_end <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				tokenize_char(ch, line_end);
			if (!in_valid || !in_stall) begin
				if (pending_chars.size() != 0
						&& !(pending_chars[0].wait_drain && expected_tokens.size() != 0)
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					ch <= pending_chars[0].c;
					line_end <= pending_chars[0].eol;
					void'(pending_chars.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		token_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected word, char %0h kind %0d", $time, out_char, kind);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("out_char", want.c, out_char);
					check_field("kind", want.k, kind);
					check_field("token_last", want.last, token_last);
					check_field("doc_count", want.docs, doc_count);
					check_field("doc_closed", want.closed, doc_closed);
					check_field("doc_length", want.len, doc_length);
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		int idle_set [4];
		int stall_set [4];
		idle_set = '{0, 83, 0, 28};
		stall_set = '{0, 0, 83, 28};
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Delimiter runs, an id that looks like a tag, an empty document, words with
		// and without letters, high and low bytes, and words at the length limit.
		push_text("  \n\n<DOCNO> <DOCNO> </DOC>\nAb9Cz 123 ");
		push_char(8'hFF);
		push_char(8'h00);
		push_char(8'h80);
		push_eol();
		push_text("ABCDEFGHIJKLMNOPQRSTUVWX\nabcdefghijklmnopqrstuvwxY\n");
		while (pending_chars.size() != 0)
			@(negedge clk);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			push_char(SPACE, 1'b0, 1);
			push_random_phase(8);
			while (pending_chars.size() != 0)
				@(negedge clk);
		end
		push_eol();

		while (pending_chars.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_tokens.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tkz_pkg.sv
rtl/tkz_ctrl.sv
rtl/tkz_dp.sv
rtl/document_tokenizer.sv
tb/testbench.sv
